/* src/bbn_pkg.sv */
// Shared constants, register indexes and controller/datapath interface types.
package bbn_pkg;

    localparam int MaxVertices = 64;
    localparam int AddrW       = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
    localparam int CntW        = $clog2(MaxVertices + 1);

    localparam int CoordW    = 16;
    localparam int ColorW    = 24;
    localparam int ChanW     = 8;
    localparam int InDataW   = 3 * CoordW;
    localparam int OutDataW  = 3 * CoordW + 3 * ChanW;
    localparam int CfgAddrW  = 1;

    // Configuration register indexes.
    localparam logic [CfgAddrW-1:0] RegFloorColor = 1'b0;
    localparam logic [CfgAddrW-1:0] RegHouseColor = 1'b1;

    localparam logic [ColorW-1:0] FloorColorReset = 24'h808080;
    localparam logic [ColorW-1:0] HouseColorReset = 24'hFF0000;

    localparam logic signed [CoordW-1:0] CoordMax = 16'sh7FFF;
    localparam logic signed [CoordW-1:0] CoordMin = -16'sh8000;

    // Offset that moves the [0, 2] scaled value down to [-1, 1] in Q1.14.
    localparam logic [CoordW-1:0] HalfScale = 16'd16384;

    typedef struct packed {
        logic             load_en;
        logic             rd_en;
        logic             div_start;
        logic             capture;
        logic             clear_set;
        logic             is_last;
        logic [AddrW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [CntW-1:0] count;
        logic            div_done;
    } t_status;

endpackage

/* src/bbn_div.sv */
// Shift-subtract divider computing (65536*num + range) / (2*range), one quotient bit a cycle.
module bbn_div
    import bbn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CoordW-1:0] i_num,
    input  logic [CoordW-1:0] i_range,
    output logic [CoordW-1:0] o_quo,
    output logic              o_done
);

    localparam int StepW = $clog2(CoordW + 1);

    logic [CoordW:0]     r_rem;
    logic [CoordW-1:0]   r_low;
    logic [CoordW:0]     r_dvs;
    logic [CoordW-1:0]   r_quo;
    logic [StepW-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [CoordW+1:0]   w_trial;
    logic                w_ge;
    logic [CoordW+1:0]   w_diff;

    // The dividend's upper half is num and its lower half is range, so the
    // partial remainder starts at num and the range bits are shifted in.
    assign w_trial = {r_rem, r_low[CoordW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_num};
                r_low  <= i_range;
                r_dvs  <= {i_range, 1'b0};
                r_quo  <= '0;
                r_cnt  <= StepW'(CoordW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[CoordW:0] : w_trial[CoordW:0];
                r_low <= {r_low[CoordW-2:0], 1'b0};
                r_quo <= {r_quo[CoordW-2:0], w_ge};
                r_cnt <= r_cnt - StepW'(1);
                if (r_cnt == StepW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

/* src/bbn_datapath.sv */
// Vertex store, running extremes, color registers, dividers and the result register.
module bbn_datapath
    import bbn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [InDataW-1:0]  i_vertex,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [ColorW-1:0]   i_cfg_wdata,
    output logic [OutDataW-1:0] o_result,
    output logic                o_overflowed,
    output logic                o_last
);

    logic [InDataW-1:0]        r_mem [MaxVertices];
    logic [InDataW-1:0]        r_rd_data;
    logic [CntW-1:0]           r_count;
    logic signed [CoordW-1:0]  r_min_x, r_max_x, r_min_z, r_max_z;
    logic                      r_drop;
    logic [ColorW-1:0]         r_floor_color, r_house_color;
    logic [OutDataW-1:0]       r_result;
    logic                      r_overflowed;
    logic                      r_last;

    logic signed [CoordW-1:0]  w_in_x, w_in_z;
    logic signed [CoordW-1:0]  w_st_x, w_st_y, w_st_z;
    logic                      w_room;
    logic [CoordW:0]           w_num_x, w_num_z, w_rng_x, w_rng_z;
    logic [CoordW-1:0]         w_quo_x, w_quo_z;
    logic                      w_done_x, w_done_z;
    logic [CoordW-1:0]         w_norm_x, w_norm_z;
    logic [ColorW-1:0]         w_color;

    assign w_in_x = i_vertex[CoordW-1:0];
    assign w_in_z = i_vertex[3*CoordW-1:2*CoordW];
    assign w_st_x = r_rd_data[CoordW-1:0];
    assign w_st_y = r_rd_data[2*CoordW-1:CoordW];
    assign w_st_z = r_rd_data[3*CoordW-1:2*CoordW];
    assign w_room = (r_count < CntW'(MaxVertices));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en && w_room) begin
            r_mem[r_count[AddrW-1:0]] <= i_vertex;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_set) begin
            r_count <= '0;
            r_min_x <= CoordMax;
            r_max_x <= CoordMin;
            r_min_z <= CoordMax;
            r_max_z <= CoordMin;
            r_drop  <= 1'b0;
        end else if (i_cmd.load_en) begin
            if (w_room) begin
                r_count <= r_count + CntW'(1);
                if (w_in_x < r_min_x) r_min_x <= w_in_x;
                if (w_in_x > r_max_x) r_max_x <= w_in_x;
                if (w_in_z < r_min_z) r_min_z <= w_in_z;
                if (w_in_z > r_max_z) r_max_z <= w_in_z;
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_color <= FloorColorReset;
            r_house_color <= HouseColorReset;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegFloorColor: r_floor_color <= i_cfg_wdata;
                RegHouseColor: r_house_color <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stored vertices always lie inside the extremes, so the offsets are
    // never negative and fit 16 unsigned bits.
    assign w_num_x = {w_st_x[CoordW-1], w_st_x} - {r_min_x[CoordW-1], r_min_x};
    assign w_num_z = {w_st_z[CoordW-1], w_st_z} - {r_min_z[CoordW-1], r_min_z};
    assign w_rng_x = {r_max_x[CoordW-1], r_max_x} - {r_min_x[CoordW-1], r_min_x};
    assign w_rng_z = {r_max_z[CoordW-1], r_max_z} - {r_min_z[CoordW-1], r_min_z};

    bbn_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num_x[CoordW-1:0]),
        .i_range (w_rng_x[CoordW-1:0]),
        .o_quo   (w_quo_x),
        .o_done  (w_done_x)
    );

    bbn_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num_z[CoordW-1:0]),
        .i_range (w_rng_z[CoordW-1:0]),
        .o_quo   (w_quo_z),
        .o_done  (w_done_z)
    );

    // A flat axis maps every vertex to zero.
    assign w_norm_x = (r_max_x == r_min_x) ? '0 : (w_quo_x - HalfScale);
    assign w_norm_z = (r_max_z == r_min_z) ? '0 : (w_quo_z - HalfScale);
    assign w_color  = (w_st_y == '0) ? r_floor_color : r_house_color;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_result     <= {w_color[ChanW-1:0], w_color[2*ChanW-1:ChanW],
                             w_color[3*ChanW-1:2*ChanW], w_st_y, w_norm_z, w_norm_x};
            r_overflowed <= r_drop;
            r_last       <= i_cmd.is_last;
        end
    end

    assign o_status.count    = r_count;
    assign o_status.div_done = w_done_x & w_done_z;
    assign o_result          = r_result;
    assign o_overflowed      = r_overflowed;
    assign o_last            = r_last;

endmodule

/* src/bbn_ctrl.sv */
// Controller state machine sequencing vertex load and result emission.
module bbn_ctrl
    import bbn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_START,
        S_DIV,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [AddrW-1:0] r_idx;
    logic             w_accept;
    logic             w_is_last;
    logic             w_out_xfer;

    assign w_accept   = (r_state == S_LOAD) && i_in_valid;
    assign w_is_last  = ((CntW'(r_idx) + CntW'(1)) == i_status.count);
    assign w_out_xfer = (r_state == S_OUT) && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_accept && i_in_last) begin
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ:  r_state <= S_START;
                S_START: r_state <= S_DIV;
                S_DIV: begin
                    if (i_status.div_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (w_is_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + AddrW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_LOAD);
    assign o_out_valid     = (r_state == S_OUT);
    assign o_cmd.load_en   = w_accept;
    assign o_cmd.rd_en     = (r_state == S_READ);
    assign o_cmd.div_start = (r_state == S_START);
    assign o_cmd.capture   = (r_state == S_DIV) && i_status.div_done;
    assign o_cmd.clear_set = w_out_xfer && w_is_last;
    assign o_cmd.is_last   = w_is_last;
    assign o_cmd.idx       = r_idx;

endmodule

/* src/bounding_box_normalizer.sv */
// Top level of the bounding-box normalizer: stream ports, controller and datapath.
//
// The block collects a set of 3D vertices (signed Q8.8 x, y, z) into a 64-entry
// store, one vertex per cycle, while tracking the minimum and maximum of x and z.
// The transaction with tlast set closes the set; the vertex it carries is stored
// too. The block then emits one result per stored vertex in load order: x and z
// mapped onto [-1, 1] as signed Q1.14 (round(32768*(v-min)/range) - 16384, halves
// rounded up; an axis with zero range gives 0), y passed through as depth, and
// the floor color when y is zero or the house color otherwise. Vertices arriving
// while the store is full are dropped without touching the extremes, and every
// result of that set then carries the overflow flag in tuser. While a set is
// emitted no vertex is accepted. Each result passes through a store read, a
// divider start, the divider steps, a capture and the output state, which waits
// for the downstream side; the pair of 16-step shift-subtract dividers (one for
// x, one for z) runs these steps once per result. The color registers are
// written through the plain write port (index 0 floor color, index 1 house color,
// RGB with red in bits 23:16); the user writes them only while the block is idle,
// which the block itself does not enforce. They keep their values across sets.
module bounding_box_normalizer
    import bbn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Vertex input stream.
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [InDataW-1:0]  i_s_axis_tdata,   // coord_x, coord_y, coord_z
    input  logic                i_s_axis_tlast,   // last_vertex
    // Result output stream.
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [OutDataW-1:0] o_m_axis_tdata,   // norm_x, norm_z, depth, red, green, blue
    output logic                o_m_axis_tuser,   // overflowed
    output logic                o_m_axis_tlast,   // last_result
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [ColorW-1:0]   i_cfg_wdata
);

    t_cmd    w_cmd;
    t_status w_status;

    // The controller owns the handshakes and the emit index; the datapath owns
    // the store, the set statistics and the arithmetic.
    bbn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_last   (i_s_axis_tlast),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    bbn_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_vertex     (i_s_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_result     (o_m_axis_tdata),
        .o_overflowed (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast)
    );

endmodule
